// ===== sv/sfb_pkg.sv =====
// Shared types and constants for the seam feather blend pipeline.
package sfb_pkg;

  localparam int COL_W      = 11;
  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int START_W    = 11;
  localparam int SPAN_W     = 12;
  localparam int NUM_W      = PIX_W + SPAN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_COLUMNS = 2048;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  localparam logic [START_W-1:0] START_RESET = 11'd0;
  localparam logic [SPAN_W-1:0]  WIDTH_RESET = 12'd960;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'b1;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;

  // weighted sum per channel plus the divisor it goes with
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] num;
    logic [SPAN_W-1:0]            span;
  } div_in_t;

endpackage

// ===== sv/sfb_front.sv =====
// Front stages: overlap decode, channel weights, products and weighted sum.
module sfb_front import sfb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic [COL_W-1:0]   column_i,
  input  pixel_t             base_i,
  input  pixel_t             warp_i,
  input  logic [START_W-1:0] overlap_start_i,
  input  logic [SPAN_W-1:0]  image_width_i,
  output logic               out_valid_o,
  output div_in_t            out_o
);

  // stage 1: input register
  logic               v1_q;
  logic [COL_W-1:0]   col1_q;
  pixel_t             base1_q, warp1_q;

  // stage 2: weights
  logic               v2_q;
  pixel_t             base2_q, warp2_q;
  logic [COL_W-1:0]   k2_q, k2_d;
  logic [SPAN_W-1:0]  sk2_q, sk2_d;
  logic [SPAN_W-1:0]  span2_q, span2_d;

  // stage 3: products
  logic                                v3_q;
  logic [NUM_CH-1:0][NUM_W-1:0]        pb3_q, pb3_d;
  logic [NUM_CH-1:0][NUM_W-1:0]        pw3_q, pw3_d;
  logic [SPAN_W-1:0]                   span3_q;
  logic [COL_W-1:0]                    k3_q;
  logic [SPAN_W-1:0]                   sk3_q;

  // stage 4: sums
  logic    v4_q;
  div_in_t d4_q, d4_d;

  logic in_ramp, warp_black, base_black;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col1_q  <= column_i;
      base1_q <= base_i;
      warp1_q <= warp_i;
      base2_q <= base1_q;
      warp2_q <= warp1_q;
      k2_q    <= k2_d;
      sk2_q   <= sk2_d;
      span2_q <= span2_d;
      pb3_q   <= pb3_d;
      pw3_q   <= pw3_d;
      span3_q <= span2_q;
      k3_q    <= k2_q;
      sk3_q   <= sk2_q;
      d4_q    <= d4_d;
    end
  end

  // Outside the overlap, or with a black pixel on either side, the weights
  // pick one pixel whole and the divisor becomes one.
  always_comb begin
    in_ramp = (col1_q >= overlap_start_i) && ({1'b0, col1_q} < image_width_i) &&
              (32'(col1_q) < MAX_COLUMNS);
    warp_black = (warp1_q == '0);
    base_black = (base1_q == '0);
    if (!in_ramp || warp_black) begin
      k2_d    = '0;
      sk2_d   = SPAN_W'(1);
      span2_d = SPAN_W'(1);
    end else if (base_black) begin
      k2_d    = COL_W'(1);
      sk2_d   = '0;
      span2_d = SPAN_W'(1);
    end else begin
      k2_d    = col1_q - overlap_start_i;
      span2_d = image_width_i - {1'b0, overlap_start_i};
      sk2_d   = span2_d - {1'b0, k2_d};
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pb3_d[c] = {{SPAN_W{1'b0}}, base2_q[c]} * {{PIX_W{1'b0}}, sk2_q};
      pw3_d[c] = {{SPAN_W{1'b0}}, warp2_q[c]} * {{(NUM_W-COL_W){1'b0}}, k2_q};
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      d4_d.num[c] = pb3_q[c] + pw3_q[c];
    end
    d4_d.span = span3_q;
  end

  assign out_valid_o = v4_q;
  assign out_o       = d4_q;

  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> span2_q != '0)
    else $error("zero divisor entered the pipeline");

  a_weights_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ({1'b0, k3_q} + sk3_q) == span3_q)
    else $error("channel weights do not add up to the divisor");

endmodule

// ===== sv/sfb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, all channels.
module sfb_div import sfb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    in_valid_i,
  input  div_in_t in_i,
  output logic    out_valid_o,
  output pixel_t  quot_o
);

  localparam int STAGES = PIX_W;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                         v_in;
    logic [NUM_CH-1:0][NUM_W-1:0] rem_in;
    logic [NUM_CH-1:0][PIX_W-1:0] quo_in;
    logic [SPAN_W-1:0]            span_in;
    logic [NUM_W-1:0]             trial;
    logic                         v_q;
    logic [NUM_CH-1:0][NUM_W-1:0] rem_q, rem_d;
    logic [NUM_CH-1:0][PIX_W-1:0] quo_q, quo_d;
    logic [SPAN_W-1:0]            span_q;

    // first stage takes the item straight from the front registers
    if (s == 0) begin : g_head
      assign v_in    = in_valid_i;
      assign rem_in  = in_i.num;
      assign quo_in  = '0;
      assign span_in = in_i.span;
    end else begin : g_link
      assign v_in    = g_stage[s-1].v_q;
      assign rem_in  = g_stage[s-1].rem_q;
      assign quo_in  = g_stage[s-1].quo_q;
      assign span_in = g_stage[s-1].span_q;
    end

    assign trial = {{PIX_W{1'b0}}, span_in} << (STAGES - 1 - s);

    // settles quotient bit STAGES-1-s, MSB first
    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        quo_d[c] = quo_in[c];
        if (rem_in[c] >= trial) begin
          rem_d[c] = rem_in[c] - trial;
          quo_d[c][STAGES-1-s] = 1'b1;
        end else begin
          rem_d[c] = rem_in[c];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        span_q <= span_in;
      end
    end
  end

  assign out_valid_o = g_stage[STAGES-1].v_q;
  assign quot_o      = g_stage[STAGES-1].quo_q;

  a_num_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (in_i.num[0] < ({{PIX_W{1'b0}}, in_i.span} << PIX_W)) &&
                   (in_i.num[1] < ({{PIX_W{1'b0}}, in_i.span} << PIX_W)) &&
                   (in_i.num[2] < ({{PIX_W{1'b0}}, in_i.span} << PIX_W)))
    else $error("weighted sum overflows the quotient width");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_stage[STAGES-1].v_q |->
      (g_stage[STAGES-1].rem_q[0] < {{PIX_W{1'b0}}, g_stage[STAGES-1].span_q}) &&
      (g_stage[STAGES-1].rem_q[1] < {{PIX_W{1'b0}}, g_stage[STAGES-1].span_q}) &&
      (g_stage[STAGES-1].rem_q[2] < {{PIX_W{1'b0}}, g_stage[STAGES-1].span_q}))
    else $error("final remainder not below the divisor");

endmodule

// ===== sv/seam_feather_blend.sv =====
// Top level of the seam feather blend: config registers, stall control, packing.
//
// Blends one pixel of the overlap between a base and a warped image per item.
// Inside the overlap (overlap_start <= column < image_width) a black warped
// pixel yields the base pixel, a black base pixel yields the warped pixel, and
// otherwise every channel is floor((base*(W-k) + warp*k) / W) with
// k = column - overlap_start and W = image_width - overlap_start; elsewhere
// the base pixel passes through. One item is taken per clock unless the output
// stalls. Stages in order: input register, weight decode, three 8x12 and
// three 8x11 multipliers per pixel, the weighted sum, then eight divider stages
// that each settle one quotient bit for all three channels, the last of which
// is the output register. A stalled output freezes the whole pipeline, so
// s_axis_tready drops only while a result is waiting on m_axis_tready.
// Config writes are taken at once and must only happen while the pipe is empty.
module seam_feather_blend import sfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // column, base_blue, base_green, base_red, warp_blue, warp_green, warp_red
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // result out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_blue, out_green, out_red
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // config writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [START_W-1:0] overlap_start_q;
  logic [SPAN_W-1:0]  image_width_q;

  logic       en;
  logic       front_valid;
  div_in_t    front_out;
  pixel_t     base_px, warp_px, out_px;
  logic [COL_W-1:0] column;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_start_q <= START_RESET;
      image_width_q   <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OVERLAP_START: overlap_start_q <= cfg_data_i[START_W-1:0];
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack: column in the low bits, then base BGR, then warp BGR
  always_comb begin
    column = s_axis_tdata[COL_W-1:0];
    for (int c = 0; c < NUM_CH; c++) begin
      base_px[c] = s_axis_tdata[COL_W + c*PIX_W +: PIX_W];
      warp_px[c] = s_axis_tdata[COL_W + (NUM_CH + c)*PIX_W +: PIX_W];
    end
  end

  // whole pipe advances unless a finished result is held back
  assign en            = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;

  sfb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (s_axis_tvalid),
    .column_i        (column),
    .base_i          (base_px),
    .warp_i          (warp_px),
    .overlap_start_i (overlap_start_q),
    .image_width_i   (image_width_q),
    .out_valid_o     (front_valid),
    .out_o           (front_out)
  );

  sfb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (front_valid),
    .in_i        (front_out),
    .out_valid_o (m_axis_tvalid),
    .quot_o      (out_px)
  );

  assign m_axis_tdata = out_px;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("pipeline moved during an output stall");

  a_width_reset: assert property (@(posedge clk_i)
    !rst_ni |=> (image_width_q == WIDTH_RESET) || $past(cfg_we_i))
    else $error("image width register lost its reset value");

endmodule

// ===== tb/tb_seam_feather_blend.sv =====
// Self-checking stream testbench for the seam feather blend pixel pipeline.
`timescale 1ns / 1ps

module tb_seam_feather_blend;
  import sfb_pkg::*;

  localparam int PIPE_LAT   = 12;       // depth of the pipeline from input item to result
  localparam int CYCLE_LIMIT = 600000;  // far beyond the slowest correct run
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 175;      // random items per register setting

  // one directed row: register setting, pixel item, optional hand-typed result
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SPAN_W-1:0]  width;
    logic [COL_W-1:0]   col;
    pixel_t             base;
    pixel_t             warp;
    logic               typed;
    pixel_t             exp;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  // pixels are written 24'hRRGGBB, blue sits in the low byte
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // reset setting: start 0, width 960
    '{11'd0,    12'd960,  11'd0,    24'h030201, 24'h060504, 1'b1, 24'h030201}, // ramp left edge
    '{11'd0,    12'd960,  11'd959,  24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF}, // black warp
    '{11'd0,    12'd960,  11'd100,  24'h000000, 24'h80C0FF, 1'b1, 24'h80C0FF}, // black base
    '{11'd0,    12'd960,  11'd500,  24'h000000, 24'h000000, 1'b1, 24'h000000}, // both black
    '{11'd0,    12'd960,  11'd960,  24'h123456, 24'hABCDEF, 1'b1, 24'h123456}, // right of ramp
    '{11'd0,    12'd960,  11'd2047, 24'hFFFFFF, 24'h010101, 1'b1, 24'hFFFFFF}, // last column
    '{11'd0,    12'd960,  11'd480,  24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF}, // saturated mix
    '{11'd0,    12'd960,  11'd480,  24'hFF00FF, 24'h00FF00, 1'b0, 24'h000000},
    '{11'd0,    12'd960,  11'd959,  24'h010000, 24'hFFFFFF, 1'b0, 24'h000000},
    '{11'd0,    12'd960,  11'd1,    24'h00007F, 24'h800000, 1'b0, 24'h000000},
    // ramp one column wide at the top of the range
    '{11'd2047, 12'd2048, 11'd2047, 24'h5A5A5A, 24'hA5A5A5, 1'b1, 24'h5A5A5A},
    '{11'd2047, 12'd2048, 11'd2046, 24'h5A5A5A, 24'hA5A5A5, 1'b1, 24'h5A5A5A}, // left of start
    '{11'd100,  12'd100,  11'd100,  24'h112233, 24'h445566, 1'b1, 24'h112233}, // start == width
    '{11'd1000, 12'd20,   11'd1000, 24'h112233, 24'h445566, 1'b1, 24'h112233}, // start > width
    '{11'd0,    12'd0,    11'd0,    24'h778899, 24'hAABBCC, 1'b1, 24'h778899}, // zero width
    '{11'd0,    12'd1,    11'd0,    24'h778899, 24'hAABBCC, 1'b1, 24'h778899}, // span of one
    '{11'd5,    12'd4095, 11'd2047, 24'h00FF80, 24'hFF0080, 1'b0, 24'h000000}, // width > columns
    '{11'd0,    12'd2048, 11'd2047, 24'hFFFFFF, 24'h000001, 1'b0, 24'h000000},
    '{11'd0,    12'd2048, 11'd1024, 24'h102030, 24'hF0E0D0, 1'b0, 24'h000000},
    '{11'd1024, 12'd2048, 11'd1535, 24'h7F7F7F, 24'h818181, 1'b0, 24'h000000}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor copy of the two registers
  logic [START_W-1:0] ovl_start = START_RESET;
  logic [SPAN_W-1:0]  img_width = WIDTH_RESET;

  pixel_t pending_px [$];     // blended pixels still owed by the pipeline
  int     err_cnt = 0;
  int     cycle_cnt = 0;
  bit     tx_calm = 1'b0;     // sender runs back to back
  bit     rx_calm = 1'b0;     // receiver starts no new stalls
  int     rx_hold = 0;

  seam_feather_blend DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // feather blend of one pixel under the current register setting
  function automatic pixel_t feather_blend(logic [COL_W-1:0] col, pixel_t base, pixel_t warp);
    pixel_t      res;
    int unsigned span;
    int unsigned k;
    int unsigned acc;
    res = base;
    if (col >= ovl_start && col < img_width && int'(col) < MAX_COLUMNS) begin
      if (warp != '0) begin
        if (base == '0) begin
          res = warp;
        end else begin
          span = int'(img_width) - int'(ovl_start);
          k    = int'(col) - int'(ovl_start);
          for (int c = 0; c < NUM_CH; c++) begin
            acc    = (int'(base[c]) * (span - k) + int'(warp[c]) * k) / span;
            res[c] = acc[PIX_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  // entered and left at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx == CFG_OVERLAP_START) ovl_start = data[START_W-1:0];
    else                          img_width = data[SPAN_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // hold the sender until every owed pixel is out and the pipe has emptied
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [START_W-1:0] start, logic [SPAN_W-1:0] width);
    wait_idle();
    // bit 11 of a start write lies outside the register and must be dropped
    write_reg(CFG_OVERLAP_START, {1'($urandom_range(0, 1)), start});
    write_reg(CFG_IMAGE_WIDTH, width);
  endtask

  // offer one item; tvalid stays up into the next item when there is no gap
  task automatic send_pixel(logic [COL_W-1:0] col, pixel_t base, pixel_t warp,
                            logic typed, pixel_t exp);
    int     gap;
    pixel_t owed_px;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 99) < 25) gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, warp, base, col};
    do @(posedge clk_i); while (!s_axis_tready);
    owed_px    = typed ? exp : feather_blend(col, base, warp);
    pending_px = {pending_px, owed_px};
    @(negedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    int r;
    pixel_t p;
    r = $urandom_range(0, 19);
    p = pixel_t'($urandom());
    if (r < 2) p = '0;                       // black, drives the two bypasses
    else if (r == 2) p = '1;
    else if (r == 3) p = pixel_t'(1 << $urandom_range(0, 23));
    return p;
  endfunction

  // columns mostly inside the ramp, with its edges hit often
  function automatic logic [COL_W-1:0] rand_col();
    int r;
    int hi;
    r  = $urandom_range(0, 9);
    hi = (int'(img_width) < MAX_COLUMNS ? int'(img_width) : MAX_COLUMNS) - 1;
    if (img_width > ovl_start && r < 7) return COL_W'($urandom_range(ovl_start, hi));
    if (r == 7) return ovl_start;
    if (r == 8) return COL_W'(img_width);
    return COL_W'($urandom_range(0, 2047));
  endfunction

  // receiver: random stalls, no new ones while rx_calm holds
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      rx_hold = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_out
    pixel_t exp_px;
    pixel_t got_px;
    string  ch_name [NUM_CH];
    ch_name = '{"out_blue", "out_green", "out_red"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_px = m_axis_tdata[NUM_CH*PIX_W-1:0];
      if (pending_px.size() == 0) begin
        $error("unexpected result %06h", got_px);
        err_cnt++;
      end else begin
        exp_px = pending_px.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got_px[c] !== exp_px[c]) begin
            $error("%s: expected %0d, actual %0d", ch_name[c], exp_px[c], got_px[c]);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [START_W-1:0] st;
    logic [SPAN_W-1:0]  wd;
    int                 r;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows, registers rewritten only when the row asks for a new setting
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].start != ovl_start || DIR_TABLE[i].width != img_width)
        set_regs(DIR_TABLE[i].start, DIR_TABLE[i].width);
      send_pixel(DIR_TABLE[i].col, DIR_TABLE[i].base, DIR_TABLE[i].warp,
                 DIR_TABLE[i].typed, DIR_TABLE[i].exp);
    end

    // random phases, the first few at the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin st = 11'd0;    wd = 12'd2048; end
        1: begin st = 11'd2047; wd = 12'd2048; end
        2: begin st = 11'd0;    wd = 12'd1;    end
        3: begin st = 11'd0;    wd = 12'd4095; end
        4: begin st = 11'd2047; wd = 12'd0;    end
        5: begin st = START_RESET; wd = WIDTH_RESET; end
        default: begin
          r  = $urandom_range(0, 9);
          st = (r < 5) ? START_W'($urandom_range(0, 255)) : START_W'($urandom_range(0, 2047));
          if (r == 9) wd = SPAN_W'($urandom_range(0, st));  // empty overlap
          else        wd = SPAN_W'((st + $urandom_range(1, 2048) > 4095) ?
                                   4095 : st + $urandom_range(1, 2048));
        end
      endcase
      set_regs(st, wd);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // sender holds off mid-phase until the pipe has drained
        if (i == PHASE_LEN / 2 && (ph == 2 || $urandom_range(0, 2) == 0)) wait_idle();
        send_pixel(rand_col(), rand_pixel(), rand_pixel(), 1'b0, '0);
      end
    end

    s_axis_tvalid = 1'b0;
    rx_calm = 1'b1;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
